>>> hdl/rsp_pkg.sv
package rsp_pkg;

	localparam int DEF_MID_DEPTH = 4;
	localparam int DEF_OUT_DEPTH = 4;

	localparam logic [2:0] KIND_POS = 3'd0;
	localparam logic [2:0] KIND_DU  = 3'd1;
	localparam logic [2:0] KIND_DV  = 3'd2;
	localparam logic [2:0] KIND_NRM = 3'd3;
	localparam logic [2:0] KIND_UU  = 3'd4;
	localparam logic [2:0] KIND_UV  = 3'd5;
	localparam logic [2:0] KIND_VV  = 3'd6;

	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_B = 2'd1;
	localparam logic [1:0] REG_C = 2'd2;

	localparam logic [15:0] A_RESET = 16'd6144;
	localparam logic [15:0] B_RESET = 16'd2048;
	localparam logic [15:0] C_RESET = 16'd4096;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [19:0] CORDIC_X0 = 20'sd39797;
	localparam logic signed [20:0] Q_PI = 21'sd205887;
	localparam logic signed [20:0] Q_HALF_PI = 21'sd102944;
	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	typedef struct packed {
		logic signed [15:0] param_u;
		logic signed [15:0] param_v;
	} req_item_t;

	typedef struct packed {
		logic [2:0] vector_kind;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic final_vector;
	} res_item_t;

	typedef struct packed {
		logic signed [19:0] s;
		logic signed [19:0] c;
		logic signed [15:0] u;
	} mid_item_t;

	function automatic logic signed [20:0] atan_step(input int i);
		case (i)
			0: return 21'sd51472;
			1: return 21'sd30386;
			2: return 21'sd16055;
			3: return 21'sd8150;
			4: return 21'sd4091;
			5: return 21'sd2047;
			6: return 21'sd1024;
			7: return 21'sd512;
			8: return 21'sd256;
			9: return 21'sd128;
			10: return 21'sd64;
			11: return 21'sd32;
			12: return 21'sd16;
			13: return 21'sd8;
			14: return 21'sd4;
			15: return 21'sd2;
			default: return 21'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		if (v > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh0000000080000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [63:0] p;
		p = x * y + 64'sd32768;
		return sat64(p >>> 16);
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return sat64(64'(x) + 64'(y));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return sat64(64'(x) - 64'(y));
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] x);
		return sat64(-64'(x));
	endfunction

endpackage

>>> hdl/rsp_fifo.sv
module rsp_fifo import rsp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_MID_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic rd,
	output logic [WIDTH-1:0] rdata,
	output logic empty,
	output logic full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign count = cnt_q;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				if (wp_q == AW'(DEPTH-1)) wp_q <= '0;
				else wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				if (rp_q == AW'(DEPTH-1)) rp_q <= '0;
				else rp_q <= rp_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> hdl/rsp_front.sv
module rsp_front import rsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_item_t req,
	input  logic mid_full,
	output logic mid_wr,
	output mid_item_t mid_data
);
	logic en;
	logic [CORDIC_STEPS:0] v_s;
	logic signed [19:0] x_s [CORDIC_STEPS+1];
	logic signed [19:0] y_s [CORDIC_STEPS+1];
	logic signed [20:0] z_s [CORDIC_STEPS+1];
	logic flip_s [CORDIC_STEPS+1];
	logic signed [15:0] u_s [CORDIC_STEPS+1];
	logic signed [20:0] z_in, z_red;
	logic flip_in;

	// hold the whole pipe while the finished item cannot enter the queue
	assign en = !(v_s[CORDIC_STEPS] && mid_full);
	assign full = !en;

	// fold the angle into +-pi/2, negate both results later
	always_comb begin
		z_in = {{2{req.param_v[15]}}, req.param_v, 3'b000};
		z_red = z_in;
		flip_in = 1'b0;
		if (z_in > Q_HALF_PI) begin
			z_red = z_in - Q_PI;
			flip_in = 1'b1;
		end else if (z_in < -Q_HALF_PI) begin
			z_red = z_in + Q_PI;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[CORDIC_STEPS-1:0], push};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_X0;
			y_s[0] <= '0;
			z_s[0] <= z_red;
			flip_s[0] <= flip_in;
			u_s[0] <= req.param_u;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [20:0] ang;
		assign ang = atan_step(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ang;
				end
				flip_s[i+1] <= flip_s[i];
				u_s[i+1] <= u_s[i];
			end
		end
	end

	assign mid_wr = v_s[CORDIC_STEPS] && en;
	assign mid_data.s = flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
	assign mid_data.c = flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
	assign mid_data.u = u_s[CORDIC_STEPS];
endmodule

>>> hdl/rsp_back.sv
module rsp_back import rsp_pkg::*; #(
	parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic mid_empty,
	output logic mid_rd,
	input  mid_item_t mid_data,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic out_wr,
	output res_item_t out_data
);
	logic [15:0] coef_a_q, coef_b_q, coef_c_q;
	logic signed [31:0] a_w, b_w, c_w, amb_w, bma_w, c2_w;
	logic signed [31:0] sw, cw, uw;
	logic en_b, e_free, issue, load;
	logic v1_s, v2_s, v3_s;

	logic signed [31:0] s1_s, c1_s, u1_s, ss1_s, cc1_s, sc1_s, bu1_s, cu1_s;
	logic signed [31:0] ab1_s, ta1_s, cs1_s, uamb1_s;
	logic signed [31:0] s2_s, c2_s, ss2_s, sc2_s, bu2_s, cu2_s, cc2_s, cs2_s;
	logic signed [31:0] pxc2_s, cub2_s, scs2_s, tp2_s, tq2_s, abss2_s, abu2_s, bbu2_s;
	logic signed [31:0] s3_s, c3_s, ss3_s, sc3_s, bu3_s, cu3_s, vdx3_s;
	logic signed [31:0] nx3_s, ny3_s, nz3_s, cux3_s, cmss3_s;

	logic ev_q, rv_q;
	logic [2:0] kind_q, rk_q;
	logic signed [31:0] es_q, ec_q, ess_q, esc_q, ebu_q, ecu_q, evdx_q;
	logic signed [31:0] enx_q, eny_q, enz_q, ecux_q, ecmss_q;
	logic signed [31:0] ox0, ox1, oy0, oy1, oz0, oz1;
	logic signed [31:0] rx_q, ry_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= A_RESET;
			coef_b_q <= B_RESET;
			coef_c_q <= C_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_A: coef_a_q <= cfg_data;
				REG_B: coef_b_q <= cfg_data;
				REG_C: coef_c_q <= cfg_data;
				default: coef_a_q <= coef_a_q;
			endcase
		end
	end

	assign a_w = {{12{coef_a_q[15]}}, coef_a_q, 4'b0000};
	assign b_w = {{12{coef_b_q[15]}}, coef_b_q, 4'b0000};
	assign c_w = {{12{coef_c_q[15]}}, coef_c_q, 4'b0000};
	assign amb_w = qsub(a_w, b_w);
	assign bma_w = qsub(b_w, a_w);
	assign c2_w = qadd(c_w, c_w);
	assign sw = {{12{mid_data.s[19]}}, mid_data.s};
	assign cw = {{12{mid_data.c[19]}}, mid_data.c};
	assign uw = {{14{mid_data.u[15]}}, mid_data.u, 2'b00};

	// emitter frees up on its last vector, so a new item follows directly
	assign e_free = !ev_q || (issue && kind_q == KIND_VV);
	assign en_b = !(v3_s && !e_free);
	assign load = v3_s && e_free;
	assign mid_rd = !mid_empty && en_b;
	assign issue = ev_q && ((int'(out_count) + int'(rv_q)) < OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
		end else if (en_b) begin
			v1_s <= !mid_empty;
			v2_s <= v1_s;
			v3_s <= v2_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			s1_s <= sw;
			c1_s <= cw;
			u1_s <= uw;
			ss1_s <= qmul(sw, sw);
			cc1_s <= qmul(cw, cw);
			sc1_s <= qmul(sw, cw);
			bu1_s <= qmul(b_w, uw);
			cu1_s <= qmul(c_w, uw);
			ab1_s <= qmul(a_w, b_w);
			ta1_s <= qmul(qsub(Q_ONE, uw), a_w);
			cs1_s <= qmul(c_w, sw);
			uamb1_s <= qmul(uw, amb_w);

			s2_s <= s1_s;
			c2_s <= c1_s;
			ss2_s <= ss1_s;
			sc2_s <= sc1_s;
			bu2_s <= bu1_s;
			cu2_s <= cu1_s;
			cc2_s <= cc1_s;
			cs2_s <= cs1_s;
			pxc2_s <= qadd(ta1_s, bu1_s);
			cub2_s <= qmul(cu1_s, b_w);
			scs2_s <= qmul(sc1_s, s1_s);
			tp2_s <= qmul(uamb1_s, qadd(cc1_s, Q_ONE));
			tq2_s <= qmul(a_w, qsub(cc1_s, Q_ONE));
			abss2_s <= qmul(ab1_s, ss1_s);
			abu2_s <= qmul(ab1_s, u1_s);
			bbu2_s <= qmul(b_w, bu1_s);

			s3_s <= s2_s;
			c3_s <= c2_s;
			ss3_s <= ss2_s;
			sc3_s <= sc2_s;
			bu3_s <= bu2_s;
			cu3_s <= cu2_s;
			vdx3_s <= qneg(pxc2_s);
			nx3_s <= qmul(cub2_s, scs2_s);
			ny3_s <= qmul(cs2_s, qadd(tp2_s, tq2_s));
			nz3_s <= qadd(qsub(abss2_s, abu2_s), bbu2_s);
			cux3_s <= qadd(cu2_s, cu2_s);
			cmss3_s <= qsub(cc2_s, ss2_s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= 1'b0;
			kind_q <= KIND_POS;
			rv_q <= 1'b0;
			rk_q <= KIND_POS;
		end else begin
			if (load) begin
				ev_q <= 1'b1;
				kind_q <= KIND_POS;
			end else if (issue) begin
				if (kind_q == KIND_VV) begin
					ev_q <= 1'b0;
					kind_q <= KIND_POS;
				end else begin
					kind_q <= kind_q + 1'b1;
				end
			end
			rv_q <= issue;
			if (issue) rk_q <= kind_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			es_q <= s3_s;
			ec_q <= c3_s;
			ess_q <= ss3_s;
			esc_q <= sc3_s;
			ebu_q <= bu3_s;
			ecu_q <= cu3_s;
			evdx_q <= vdx3_s;
			enx_q <= nx3_s;
			eny_q <= ny3_s;
			enz_q <= nz3_s;
			ecux_q <= cux3_s;
			ecmss_q <= cmss3_s;
		end
		if (issue) begin
			rx_q <= qmul(ox0, ox1);
			ry_q <= qmul(oy0, oy1);
			rz_q <= qmul(oz0, oz1);
		end
	end

	// normal is already done: pass it through a multiply by one
	always_comb begin
		ox0 = '0; ox1 = '0; oy0 = '0; oy1 = '0; oz0 = '0; oz1 = '0;
		case (kind_q)
			KIND_POS: begin
				ox0 = qneg(evdx_q); ox1 = ec_q;
				oy0 = ebu_q; oy1 = es_q;
				oz0 = ecu_q; oz1 = ess_q;
			end
			KIND_DU: begin
				ox0 = ec_q; ox1 = bma_w;
				oy0 = b_w; oy1 = es_q;
				oz0 = c_w; oz1 = ess_q;
			end
			KIND_DV: begin
				ox0 = es_q; ox1 = evdx_q;
				oy0 = ebu_q; oy1 = ec_q;
				oz0 = ecux_q; oz1 = esc_q;
			end
			KIND_NRM: begin
				ox0 = enx_q; ox1 = Q_ONE;
				oy0 = eny_q; oy1 = Q_ONE;
				oz0 = enz_q; oz1 = Q_ONE;
			end
			KIND_UV: begin
				ox0 = es_q; ox1 = amb_w;
				oy0 = b_w; oy1 = ec_q;
				oz0 = c2_w; oz1 = esc_q;
			end
			KIND_VV: begin
				ox0 = ec_q; ox1 = evdx_q;
				oy0 = ebu_q; oy1 = es_q;
				oz0 = ecux_q; oz1 = ecmss_q;
			end
			default: begin
				ox0 = '0;
			end
		endcase
	end

	assign out_wr = rv_q;
	assign out_data.vector_kind = rk_q;
	assign out_data.vec_x = rx_q;
	assign out_data.vec_y = (rk_q == KIND_VV) ? qneg(ry_q) : ry_q;
	assign out_data.vec_z = rz_q;
	assign out_data.final_vector = (rk_q == KIND_VV);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q |-> kind_q <= KIND_VV)
		else $error("emitter kind out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> int'(out_count) < OUT_DEPTH)
		else $error("result queue overrun");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && kind_q == KIND_VV) |=> (kind_q == KIND_POS) && rv_q)
		else $error("emitter did not restart after last vector");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !issue) |-> !ev_q)
		else $error("emitter loaded while busy");
endmodule

>>> hdl/ruled_surface_point_and_derivatives_unit.sv
// Path: sine/cosine pipeline, request queue, product stages, emitter, result register.
// The other six vectors follow the first, one per cycle while the result queue has room.
// Throughput: set by the single vector emitter (three multipliers, one vector a cycle
// while the result queue has room), which takes the next request with its last vector.
// Reset: arst_n clears all control state and loads a=1.5, b=0.5, c=1.0.
module ruled_surface_point_and_derivatives_unit import rsp_pkg::*; #(
	parameter int MID_DEPTH = DEF_MID_DEPTH,
	parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_item_t req,
	output logic empty,
	input  logic pop,
	output res_item_t res,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data
);
	logic mid_wr, mid_rd, mid_empty, mid_full, out_wr, out_full;
	mid_item_t mid_wdata, mid_rdata;
	res_item_t out_wdata;
	logic [$bits(mid_item_t)-1:0] mid_rbits;
	logic [$bits(res_item_t)-1:0] out_rbits;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	rsp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.mid_full(mid_full), .mid_wr(mid_wr), .mid_data(mid_wdata)
	);

	rsp_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n), .wr(mid_wr), .wdata(mid_wdata),
		.rd(mid_rd), .rdata(mid_rbits), .empty(mid_empty), .full(mid_full),
		.count(mid_count)
	);

	assign mid_rdata = mid_rbits;

	rsp_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .mid_empty(mid_empty), .mid_rd(mid_rd),
		.mid_data(mid_rdata), .out_count(out_count), .out_wr(out_wr),
		.out_data(out_wdata)
	);

	rsp_fifo #(.WIDTH($bits(res_item_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .wr(out_wr), .wdata(out_wdata),
		.rd(pop), .rdata(out_rbits), .empty(empty), .full(out_full),
		.count(out_count)
	);

	assign res = out_rbits;

	a_mid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		int'(mid_count) <= MID_DEPTH)
		else $error("request queue count out of range");

	a_out_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("result written into full queue");

	a_mid_space: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> !mid_full)
		else $error("request written into full queue");
endmodule

>>> tb/ruled_surface_point_and_derivatives_unit_tb.sv
`timescale 1ns / 100ps

module ruled_surface_point_and_derivatives_unit_tb;
	import rsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint FULL_ONE = 65536;
	localparam longint FULL_PI = 205887;
	localparam longint FULL_HALF_PI = 102944;
	localparam longint GAIN = 39797;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_item_t req;
	logic empty;
	logic pop;
	res_item_t res;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;

	req_item_t pending_reqs[$];
	res_item_t expected_vectors[$];
	logic [15:0] coef_a, coef_b, coef_c;
	int errors;
	int idle_cycles;
	int push_wait;
	int pop_wait;
	int pop_draw;
	bit stim_done;

	ruled_surface_point_and_derivatives_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fmul(longint x, longint y);
		return clip32(shr_floor(x * y + 32768, 16));
	endfunction

	function automatic longint fadd(longint x, longint y);
		return clip32(x + y);
	endfunction

	function automatic longint fsub(longint x, longint y);
		return clip32(x - y);
	endfunction

	function automatic longint angle_step(int i);
		longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return tab[i];
	endfunction

	task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
		longint x, y, nx, z;
		bit flip;
		x = GAIN;
		y = 0;
		z = ang;
		flip = 0;
		if (z > FULL_HALF_PI) begin
			z -= FULL_PI;
			flip = 1;
		end else if (z < -FULL_HALF_PI) begin
			z += FULL_PI;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z -= angle_step(i);
			end else begin
				nx = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z += angle_step(i);
			end
			x = nx;
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	task automatic add_vector(input logic [2:0] kind, input longint x, input longint y,
			input longint z);
		res_item_t r;
		r.vector_kind = kind;
		r.vec_x = x[31:0];
		r.vec_y = y[31:0];
		r.vec_z = z[31:0];
		r.final_vector = (kind == KIND_VV);
		expected_vectors.push_back(r);
	endtask

	task automatic predict_surface(input req_item_t it);
		longint u, v, a, b, c, s, co, ss, cc, sc, bu, cu, pxc, vdx, amb, ab;
		u = longint'(it.param_u) * 4;
		v = longint'(it.param_v) * 8;
		a = longint'($signed(coef_a)) * 16;
		b = longint'($signed(coef_b)) * 16;
		c = longint'($signed(coef_c)) * 16;
		rotate_angle(v, s, co);
		ss = fmul(s, s);
		cc = fmul(co, co);
		sc = fmul(s, co);
		bu = fmul(b, u);
		cu = fmul(c, u);
		pxc = fadd(fmul(fsub(FULL_ONE, u), a), bu);
		vdx = clip32(-pxc);
		amb = fsub(a, b);
		ab = fmul(a, b);
		add_vector(KIND_POS, fmul(pxc, co), fmul(bu, s), fmul(cu, ss));
		add_vector(KIND_DU, fmul(co, fsub(b, a)), fmul(b, s), fmul(c, ss));
		add_vector(KIND_DV, fmul(s, vdx), fmul(bu, co), fmul(fadd(cu, cu), sc));
		add_vector(KIND_NRM, fmul(fmul(cu, b), fmul(sc, s)),
			fmul(fmul(c, s), fadd(fmul(fmul(u, amb), fadd(cc, FULL_ONE)),
				fmul(a, fsub(cc, FULL_ONE)))),
			fadd(fsub(fmul(ab, ss), fmul(ab, u)), fmul(b, bu)));
		add_vector(KIND_UU, 0, 0, 0);
		add_vector(KIND_UV, fmul(s, amb), fmul(b, co), fmul(fadd(c, c), sc));
		add_vector(KIND_VV, fmul(co, vdx), clip32(-fmul(bu, s)),
			fmul(fadd(cu, cu), fsub(cc, ss)));
	endtask

	task automatic report_mismatch(input string what, input res_item_t got,
			input res_item_t want);
		errors++;
		$display("mismatch %s: got k=%0d x=%0d y=%0d z=%0d f=%0b want k=%0d x=%0d y=%0d z=%0d f=%0b",
			what, got.vector_kind, got.vec_x, got.vec_y, got.vec_z, got.final_vector,
			want.vector_kind, want.vec_x, want.vec_y, want.vec_z, want.final_vector);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			req <= '0;
			push_wait <= 0;
		end else begin
			if (push && !full) begin
				predict_surface(req);
			end
			if (push && full) begin
				// hold the request
			end else if (push_wait > 0) begin
				push <= 1'b0;
				push_wait <= push_wait - 1;
			end else if (pending_reqs.size() > 0) begin
				push <= 1'b1;
				req <= pending_reqs.pop_front();
				push_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_vectors.size() == 0) begin
					report_mismatch("unexpected", res, '0);
				end else if (res !== expected_vectors[0]) begin
					report_mismatch("field", res, expected_vectors.pop_front());
				end else begin
					void'(expected_vectors.pop_front());
				end
				pop_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
				pop_wait <= pop_draw;
				pop <= (pop_draw == 0);
			end else if (pop_wait > 0) begin
				pop <= 1'b0;
				pop_wait <= pop_wait - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog on accepted requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (!stim_done || expected_vectors.size() > 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic req_item_t rand_req();
		req_item_t it;
		it.param_u = 16'($urandom);
		case ($urandom_range(0, 3))
			0: it.param_v = 16'(int'($urandom_range(0, 51472)) - 25736);
			1: it.param_v = 16'(int'($urandom_range(0, 65535)) - 32768);
			default: it.param_v = 16'(int'($urandom_range(0, 25736)) - 12868);
		endcase
		return it;
	endfunction

	task automatic write_coef(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_A: coef_a = val;
			REG_B: coef_b = val;
			REG_C: coef_c = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || push || expected_vectors.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int count);
		for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req());
		wait_idle();
	endtask

	initial begin
		logic signed [15:0] edge_u[5] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd16384};
		logic signed [15:0] edge_v[8] = '{-16'sd32768, 16'sd32767, -16'sd25736, 16'sd25736,
			16'sd0, 16'sd12868, -16'sd12869, 16'sd12869};
		req_item_t it;
		errors = 0;
		stim_done = 0;
		coef_a = A_RESET;
		coef_b = B_RESET;
		coef_c = C_RESET;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_A;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// corners of u and v, including angles past the half-pi fold
		for (int i = 0; i < 5; i++) begin
			it.param_u = edge_u[i];
			it.param_v = edge_v[(i * 3) % 8];
			pending_reqs.push_back(it);
			it.param_v = edge_v[(i * 3 + 1) % 8];
			pending_reqs.push_back(it);
		end
		for (int i = 0; i < 8; i++) begin
			it.param_u = 16'sd8192;
			it.param_v = edge_v[i];
			pending_reqs.push_back(it);
		end
		wait_idle();
		run_phase(80);
		// extreme coefficients drive saturation
		write_coef(REG_A, 16'h7FFF);
		write_coef(REG_B, 16'h8000);
		write_coef(REG_C, 16'h7FFF);
		for (int i = 0; i < 5; i++) begin
			it.param_u = edge_u[i];
			it.param_v = edge_v[i + 2];
			pending_reqs.push_back(it);
		end
		run_phase(50);
		write_coef(REG_A, 16'h8000);
		write_coef(REG_B, 16'h7FFF);
		write_coef(REG_C, 16'h8000);
		run_phase(50);
		write_coef(REG_A, 16'h0000);
		write_coef(REG_B, 16'h0000);
		write_coef(REG_C, 16'h0000);
		run_phase(15);
		write_coef(REG_A, 16'($urandom));
		write_coef(REG_B, 16'($urandom));
		write_coef(REG_C, 16'($urandom));
		run_phase(80);
		stim_done = 1;
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
